// ===== sv/key_debounce_long_press_defines.svh =====
// Assertion macros shared by the key debounce modules.
`ifndef KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KDLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key debounce assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KDLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key debounce assertion failed");

`endif

// ===== sv/kdlp_pkg.sv =====
// Types, codes and constants of the key debounce block.
package kdlp_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int RAW_W        = 4;
    localparam int RAW_IDX_W    = $clog2(RAW_W);
    localparam int KEY_W        = 3;
    localparam int OP_W         = 2;
    localparam int CNT_W        = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int PHASE_W      = 2;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;
    localparam logic [CNT_W-1:0] LONG_RESET     = 8'd80;

    localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESS = 2'd1;
    localparam logic [OP_W-1:0] OP_LONG  = 2'd2;
    localparam logic [OP_W-1:0] OP_HELD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd1;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_LONG     = 2'd3;

    typedef struct packed {
        logic scan;
        logic clr_press;
        logic clr_long;
    } lane_ctrl_t;

    typedef struct packed {
        logic press;
        logic long_hit;
    } lane_stat_t;

endpackage

// ===== sv/kdlp_if.sv =====
// Handshake channels of the key debounce block: items, results, configuration.
interface kdlp_item_if import kdlp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [RAW_W-1:0] raw_levels;
    logic [KEY_W-1:0] key_id;

    modport source (output valid, op, raw_levels, key_id, input ready);
    modport sink   (input valid, op, raw_levels, key_id, output ready);
endinterface

interface kdlp_result_if ();
    logic valid;
    logic ready;
    logic answer;

    modport source (output valid, answer, input ready);
    modport sink   (input valid, answer, output ready);
endinterface

interface kdlp_cfg_if import kdlp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/key_debounce_long_press.sv =====
// Top level of the key debounce block with long-press detection.
// Channels: item (sink) takes op, raw_levels and key_id; result (source)
// returns one answer bit per item; cfg (sink) writes debounce_ticks at
// index 0 and long_press_ticks at index 1, always ready.
// A scan tick (op 0) advances every key lane at once from its raw level,
// active low. Ops 1 and 2 read and clear the press or long flag of key_id,
// op 3 returns the held level of key_id taken from the same item.
// Latency: the result is valid the cycle after the item is accepted.
// Throughput: one item per cycle unless the result stalls; every key has its own lane, so a scan
// is a single register update and a query a single lane select.
// The output register sits between the two sides: while it holds an
// untaken result the block still takes an item if result.ready is high,
// and stops taking items only when the result is stalled.
// Reset: all keys idle, counts and flags clear, thresholds 5 and 80,
// no result pending.
module key_debounce_long_press import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    kdlp_item_if.sink     item,
    kdlp_result_if.source result,
    kdlp_cfg_if.sink      cfg
);

    logic [CNT_W-1:0] debounce_reg, debounce_next;
    logic [CNT_W-1:0] long_press_reg, long_press_next;
    logic             take;
    logic             accept_ok;
    lane_stat_t       stat [NUM_KEYS];

    assign cfg.ready  = 1'b1;
    assign item.ready = accept_ok;
    assign take       = item.valid && accept_ok;

    always_comb
    begin
        debounce_next   = debounce_reg;
        long_press_next = long_press_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DEBOUNCE:   debounce_next   = cfg.data;
                CFG_LONG_PRESS: long_press_next = cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_RESET;
        end
        else
        begin
            debounce_reg   <= debounce_next;
            long_press_reg <= long_press_next;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        lane_ctrl_t ctrl;
        logic       low;

        if (k < RAW_W)
        begin : g_pin
            assign low = !item.raw_levels[k];
        end
        else
        begin : g_no_pin
            assign low = 1'b0;
        end

        assign ctrl.scan      = take && (item.op == OP_SCAN);
        assign ctrl.clr_press = take && (item.op == OP_PRESS) && (item.key_id == KEY_W'(k));
        assign ctrl.clr_long  = take && (item.op == OP_LONG) && (item.key_id == KEY_W'(k));

        kdlp_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .ctrl             (ctrl),
            .low              (low),
            .debounce_ticks   (debounce_reg),
            .long_press_ticks (long_press_reg),
            .stat             (stat[k])
        );
    end

    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .op         (item.op),
        .raw_levels (item.raw_levels),
        .key_id     (item.key_id),
        .stat       (stat),
        .accept_ok  (accept_ok),
        .result     (result)
    );

endmodule

// ===== sv/kdlp_lane.sv =====
// One key lane: four-phase debounce and long-press machine with latched flags.
`include "key_debounce_long_press_defines.svh"

module kdlp_lane import kdlp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic             low,
    input  logic [CNT_W-1:0] debounce_ticks,
    input  logic [CNT_W-1:0] long_press_ticks,
    output lane_stat_t       stat
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               press_reg, press_next;
    logic               long_reg, long_next;
    logic [CNT_W-1:0]   count_inc;

    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        press_next = press_reg;
        long_next  = long_reg;
        if (ctrl.scan)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (low)
                    begin
                        phase_next = PH_DEBOUNCE;
                        count_next = '0;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (low)
                    begin
                        count_next = count_inc;
                        if (count_inc >= debounce_ticks)
                        begin
                            phase_next = PH_PRESSED;
                            count_next = '0;
                            press_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
                PH_PRESSED:
                begin
                    if (low)
                    begin
                        count_next = count_inc;
                        if (count_inc >= long_press_ticks)
                        begin
                            phase_next = PH_LONG;
                            count_next = '0;
                            long_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
                default:
                begin
                    // long phase: wait for release
                    if (!low)
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
            endcase
        end
        if (ctrl.clr_press)
        begin
            press_next = 1'b0;
        end
        if (ctrl.clr_long)
        begin
            long_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            press_reg <= 1'b0;
            long_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            press_reg <= press_next;
            long_reg  <= long_next;
        end
    end

    assign stat.press    = press_reg;
    assign stat.long_hit = long_reg;

    `KDLP_ASSERT_NOW(a_count_clear_at_rest,
        (phase_reg == PH_IDLE) || (phase_reg == PH_LONG), count_reg == '0)
    `KDLP_ASSERT_NEXT(a_release_to_idle, ctrl.scan && !low, phase_reg == PH_IDLE)
    `KDLP_ASSERT_NOW(a_press_on_entry, $rose(press_reg), phase_reg == PH_PRESSED)
    `KDLP_ASSERT_NOW(a_long_on_entry, $rose(long_reg), phase_reg == PH_LONG)

endmodule

// ===== sv/kdlp_merge.sv =====
// Merge stage: picks the queried lane flag or held level and registers the result.
`include "key_debounce_long_press_defines.svh"

module kdlp_merge import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [OP_W-1:0]  op,
    input  logic [RAW_W-1:0] raw_levels,
    input  logic [KEY_W-1:0] key_id,
    input  lane_stat_t       stat [NUM_KEYS],
    output logic             accept_ok,
    kdlp_result_if.source    result
);

    logic valid_reg, valid_next;
    logic answer_reg, answer_next;
    logic hit;
    logic sel_press;
    logic sel_long;
    logic held;
    logic answer_sel;

    always_comb
    begin
        hit       = 1'b0;
        sel_press = 1'b0;
        sel_long  = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (key_id == KEY_W'(k))
            begin
                hit       = 1'b1;
                sel_press = stat[k].press;
                sel_long  = stat[k].long_hit;
            end
        end
    end

    // keys beyond the raw bus read released
    assign held = hit && (key_id < KEY_W'(RAW_W)) && !raw_levels[key_id[RAW_IDX_W-1:0]];

    always_comb
    begin
        case (op)
            OP_SCAN:  answer_sel = 1'b0;
            OP_PRESS: answer_sel = sel_press;
            OP_LONG:  answer_sel = sel_long;
            OP_HELD:  answer_sel = held;
            default:  answer_sel = 1'b0;
        endcase
    end

    assign accept_ok = !valid_reg || result.ready;

    always_comb
    begin
        valid_next  = valid_reg;
        answer_next = answer_reg;
        if (take)
        begin
            valid_next  = 1'b1;
            answer_next = answer_sel;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
    end

    assign result.valid  = valid_reg;
    assign result.answer = answer_reg;

    `KDLP_ASSERT_NEXT(a_take_gives_result, take, result.valid)
    `KDLP_ASSERT_NEXT(a_scan_answers_zero, take && (op == OP_SCAN), !result.answer)
    `KDLP_ASSERT_NEXT(a_bad_key_answers_zero,
        take && ({1'b0, key_id} >= (KEY_W+1)'(NUM_KEYS)), !result.answer)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the key debounce block: bursty driver, stalling monitor, predictor.
module testbench;
    import kdlp_pkg::*;

    localparam int KEYS         = NUM_KEYS_DEF;
    localparam int KEY_MAX      = (1 << KEY_W) - 1;
    localparam int NUM_SETTINGS = 7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [RAW_W-1:0] raw_levels;
        logic [KEY_W-1:0] key_id;
    } key_item_t;

    logic clk;
    logic rst_n;

    kdlp_item_if   item_ch ();
    kdlp_result_if res_ch ();
    kdlp_cfg_if    cfg_ch ();

    key_debounce_long_press #(.NUM_KEYS(KEYS)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Predicted key state and thresholds
    logic [PHASE_W-1:0] lane_phase [KEYS];
    logic [CNT_W-1:0]   lane_count [KEYS];
    logic               press_mark [KEYS];
    logic               long_mark  [KEYS];
    logic [CNT_W-1:0]   thr_debounce;
    logic [CNT_W-1:0]   thr_long;

    key_item_t pending[$];
    logic      answer_due[$];
    key_item_t in_flight;

    // Stimulus plan per key: remaining low and high scan ticks
    int low_left  [KEYS];
    int high_left [KEYS];

    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_span;
    int stall_tick;
    logic take;

    int mismatches;
    int items_taken;
    int scans_taken;
    int presses_seen;
    int longs_seen;
    int high_answers;

    logic [CNT_W-1:0] debounce_set [NUM_SETTINGS] = '{8'd5, 8'd1, 8'd3, 8'd255, 8'd1, 8'd2, 8'd0};
    logic [CNT_W-1:0] long_set     [NUM_SETTINGS] = '{8'd80, 8'd1, 8'd12, 8'd1, 8'd255, 8'd6, 8'd0};
    int               random_count [NUM_SETTINGS] = '{280, 220, 280, 420, 350, 160, 60};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("key_debounce_long_press verification failed");
        $finish;
    end

    // Advance all keys on a scan tick, or answer a query
    function automatic logic step_keys(key_item_t it);
        logic             ans;
        logic             low;
        logic [CNT_W-1:0] nxt;
        ans = 1'b0;
        if (it.op == OP_SCAN)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                low = (k < RAW_W) && !it.raw_levels[k];
                case (lane_phase[k])
                    PH_IDLE:
                    begin
                        if (low)
                        begin
                            lane_phase[k] = PH_DEBOUNCE;
                            lane_count[k] = '0;
                        end
                    end
                    PH_DEBOUNCE:
                    begin
                        nxt = lane_count[k] + 1'b1;
                        if (!low)
                        begin
                            lane_phase[k] = PH_IDLE;
                            lane_count[k] = '0;
                        end
                        else if (nxt >= thr_debounce)
                        begin
                            lane_phase[k] = PH_PRESSED;
                            lane_count[k] = '0;
                            press_mark[k] = 1'b1;
                            presses_seen++;
                        end
                        else
                            lane_count[k] = nxt;
                    end
                    PH_PRESSED:
                    begin
                        nxt = lane_count[k] + 1'b1;
                        if (!low)
                        begin
                            lane_phase[k] = PH_IDLE;
                            lane_count[k] = '0;
                        end
                        else if (nxt >= thr_long)
                        begin
                            lane_phase[k] = PH_LONG;
                            lane_count[k] = '0;
                            long_mark[k]  = 1'b1;
                            longs_seen++;
                        end
                        else
                            lane_count[k] = nxt;
                    end
                    default:
                    begin
                        if (!low)
                        begin
                            lane_phase[k] = PH_IDLE;
                            lane_count[k] = '0;
                        end
                    end
                endcase
            end
        end
        else if (it.key_id < KEYS)
        begin
            case (it.op)
                OP_PRESS:
                begin
                    ans = press_mark[it.key_id];
                    press_mark[it.key_id] = 1'b0;
                end
                OP_LONG:
                begin
                    ans = long_mark[it.key_id];
                    long_mark[it.key_id] = 1'b0;
                end
                default:
                    ans = (it.key_id < RAW_W) && !it.raw_levels[it.key_id];
            endcase
        end
        return ans;
    endfunction

    // Pick a low-hold length around the current thresholds
    function automatic int hold_plan();
        int db;
        int lp;
        db = (thr_debounce == 0) ? 1 : int'(thr_debounce);
        lp = (thr_long == 0) ? 1 : int'(thr_long);
        case ($urandom_range(0, 4))
            0:       return $urandom_range(1, db);
            1:       return $urandom_range(db + 1, db + lp);
            2:       return $urandom_range(db + lp + 1, db + lp + 10);
            3:       return db + $urandom_range(0, 1);
            default: return db + lp + $urandom_range(0, 1);
        endcase
    endfunction

    task automatic push_item(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                             input logic [KEY_W-1:0] id);
        key_item_t it;
        it.op         = op;
        it.raw_levels = raw;
        it.key_id     = id;
        pending.push_back(it);
    endtask

    task automatic queue_random_items(input int n);
        key_item_t it;
        int        pick;
        int        idx;
        for (int i = 0; i < n; i++)
        begin
            it.op         = OP_SCAN;
            it.raw_levels = '1;
            it.key_id     = KEY_W'($urandom_range(0, KEY_MAX));
            if ($urandom_range(0, 9) < 3)
            begin
                it.op         = OP_W'($urandom_range(OP_PRESS, OP_HELD));
                it.raw_levels = RAW_W'($urandom);
                if ($urandom_range(0, 6) == 0)
                    it.key_id = KEY_W'($urandom_range(KEYS, KEY_MAX));
                else
                    it.key_id = KEY_W'($urandom_range(0, KEYS - 1));
            end
            else
            begin
                for (int k = 0; k < KEYS && k < RAW_W; k++)
                begin
                    if (low_left[k] > 0)
                    begin
                        it.raw_levels[k] = 1'b0;
                        low_left[k]--;
                        if (low_left[k] == 0)
                            high_left[k] = $urandom_range(1, 6);
                    end
                    else
                    begin
                        if (high_left[k] > 0)
                            high_left[k]--;
                        if (high_left[k] == 0)
                            low_left[k] = hold_plan();
                    end
                end
                // Break a few sequences with bounce and plain noise
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    it.raw_levels = RAW_W'($urandom);
                else if (pick < 12)
                begin
                    idx = $urandom_range(0, RAW_W - 1);
                    it.raw_levels[idx] = ~it.raw_levels[idx];
                end
            end
            pending.push_back(it);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            thr_debounce = val;
        else
            thr_long = val;
        @(negedge clk);
    endtask

    // Hold off until every item is taken and answered
    task automatic drain();
        while (pending.size() != 0 || item_ch.valid || answer_due.size() != 0)
            @(negedge clk);
    endtask

    // Item driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                answer_due.push_back(step_keys(in_flight));
                items_taken++;
                if (in_flight.op == OP_SCAN)
                    scans_taken++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    in_flight = pending.pop_front();
                    item_ch.valid      <= 1'b1;
                    item_ch.op         <= in_flight.op;
                    item_ch.raw_levels <= in_flight.raw_levels;
                    item_ch.key_id     <= in_flight.key_id;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with its own stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (answer_due.size() == 0)
                begin
                    $error("answer: no item outstanding, got %0b", res_ch.answer);
                    mismatches++;
                end
                else
                begin
                    if (answer_due[0] !== res_ch.answer)
                    begin
                        $error("answer: expected %0b, got %0b", answer_due[0], res_ch.answer);
                        mismatches++;
                    end
                    if (res_ch.answer === 1'b1)
                        high_answers++;
                    void'(answer_due.pop_front());
                end
            end
            if (stall_span == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(16, 96);
            end
            stall_span--;
            stall_tick++;
            case (stall_mode)
                0:       take = 1'b1;
                1:       take = $urandom_range(0, 1);
                2:       take = ($urandom_range(0, 3) == 0);
                default: take = (stall_tick % 12) == 0;
            endcase
            res_ch.ready <= take;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.op         = OP_SCAN;
        item_ch.raw_levels = '1;
        item_ch.key_id     = '0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_DEBOUNCE;
        cfg_ch.data        = '0;
        thr_debounce       = DEBOUNCE_RESET;
        thr_long           = LONG_RESET;
        mismatches         = 0;
        items_taken        = 0;
        scans_taken        = 0;
        presses_seen       = 0;
        longs_seen         = 0;
        high_answers       = 0;
        burst_left         = 0;
        gap_left           = 0;
        stall_mode         = 0;
        stall_span         = 0;
        stall_tick         = 0;
        for (int k = 0; k < KEYS; k++)
        begin
            lane_phase[k] = PH_IDLE;
            lane_count[k] = '0;
            press_mark[k] = 1'b0;
            long_mark[k]  = 1'b0;
            low_left[k]   = 0;
            high_left[k]  = 0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            write_reg(CFG_DEBOUNCE, debounce_set[p]);
            write_reg(CFG_LONG_PRESS, long_set[p]);
            if (p == 0)
            begin
                // Held level, out-of-range keys, one full press on key 0
                push_item(OP_SCAN, 4'hF, 3'd0);
                push_item(OP_HELD, 4'h0, 3'd0);
                push_item(OP_HELD, 4'hF, 3'd3);
                push_item(OP_HELD, 4'h0, 3'd4);
                push_item(OP_PRESS, 4'h0, 3'd7);
                push_item(OP_LONG, 4'h0, 3'd5);
                repeat (6) push_item(OP_SCAN, 4'hE, 3'd0);
                push_item(OP_PRESS, 4'hF, 3'd0);
                push_item(OP_PRESS, 4'hF, 3'd0);
                push_item(OP_LONG, 4'hF, 3'd0);
                push_item(OP_SCAN, 4'h1, 3'd0);
                push_item(OP_SCAN, 4'hF, 3'd0);
                push_item(OP_HELD, 4'hB, 3'd2);
            end
            else if (p == 1)
            begin
                // Thresholds of one: all keys reach long within three ticks
                repeat (3) push_item(OP_SCAN, 4'h0, 3'd0);
                for (int k = 0; k < KEYS; k++)
                    push_item(OP_LONG, 4'h0, KEY_W'(k));
                push_item(OP_SCAN, 4'hF, 3'd0);
            end
            queue_random_items(random_count[p]);
            drain();
        end

        repeat (4) @(posedge clk);
        if (answer_due.size() != 0)
        begin
            $error("answer: %0d results never arrived", answer_due.size());
            mismatches++;
        end
        $display("Covered %0d items (%0d scan ticks) over %0d threshold settings.",
                 items_taken, scans_taken, NUM_SETTINGS);
        $display("Keys confirmed %0d presses and %0d long presses; %0d answers came back high.",
                 presses_seen, longs_seen, high_answers);
        if (mismatches == 0)
            $display("key_debounce_long_press verification clean");
        else
            $display("key_debounce_long_press verification failed");
        $finish;
    end

endmodule
